// File: sv/gtpw_pkg.sv
// ----------------------------------------------------------------------------
// gtpw_pkg: shared types, constants and glyph ROM
// Holds the 6x8 font, the scan-order conversion and the control structs that
// pass between the text pixel writer's controller and datapath.
// ----------------------------------------------------------------------------
package gtpw_pkg;

    localparam int GLYPH_COLUMNS = 6;
    localparam int GLYPH_ROWS    = 8;
    localparam int GLYPH_CELLS   = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int FONT_CODES    = 128;

    // field widths
    localparam int CODE_W   = 8;
    localparam int COORD_W  = 10;
    localparam int OFFS_W   = 10;
    localparam int LWID_W   = 11;
    localparam int POS_W    = 8;
    localparam int COL_W    = 3;
    localparam int XBASE_W  = 12;
    localparam int YSUM_W   = 11;
    localparam int ROWB_W   = 23;
    localparam int SUM_W    = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [POS_W-1:0] POS_MAX = 8'hFF;
    localparam logic [COL_W-1:0] COL_LAST = 3'(GLYPH_COLUMNS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd2;

    localparam logic [LWID_W-1:0] LINE_WIDTH_RESET = 11'd128;

    // one glyph: column bytes, element 0 is the leftmost column
    typedef logic [0:GLYPH_COLUMNS-1][7:0] t_glyph;
    // glyph bits in scan order: bit row*6+col
    typedef logic [GLYPH_CELLS-1:0] t_scan;

    typedef struct packed {
        logic load_item;
        logic load_row_base;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic mask_empty;
        logic cur_set;
        logic rest_empty;
    } t_dp_status;

    // column bytes of a 7-bit code; codes without a glyph are blank
    function automatic t_glyph glyph_lookup(input logic [6:0] code);
        t_glyph g;
        case (code)
            7'd33:  g = {8'h00, 8'h00, 8'h2F, 8'h00, 8'h00, 8'h00};
            7'd34:  g = {8'h00, 8'h03, 8'h00, 8'h03, 8'h00, 8'h00};
            7'd35:  g = {8'h14, 8'h3E, 8'h14, 8'h3E, 8'h14, 8'h00};
            7'd36:  g = {8'h12, 8'h2A, 8'h3F, 8'h2A, 8'h24, 8'h00};
            7'd37:  g = {8'h22, 8'h10, 8'h08, 8'h04, 8'h22, 8'h00};
            7'd38:  g = {8'h14, 8'h2A, 8'h2A, 8'h14, 8'h28, 8'h00};
            7'd39:  g = {8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00};
            7'd40:  g = {8'h00, 8'h1C, 8'h22, 8'h00, 8'h00, 8'h00};
            7'd41:  g = {8'h00, 8'h22, 8'h1C, 8'h00, 8'h00, 8'h00};
            7'd42:  g = {8'h14, 8'h08, 8'h3E, 8'h08, 8'h14, 8'h00};
            7'd43:  g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08, 8'h00};
            7'd44:  g = {8'h00, 8'h20, 8'h10, 8'h00, 8'h00, 8'h00};
            7'd45:  g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00};
            7'd46:  g = {8'h00, 8'h30, 8'h30, 8'h00, 8'h00, 8'h00};
            7'd47:  g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h00};
            7'd48:  g = {8'h1E, 8'h29, 8'h25, 8'h23, 8'h1E, 8'h00};
            7'd49:  g = {8'h00, 8'h22, 8'h3F, 8'h20, 8'h00, 8'h00};
            7'd50:  g = {8'h32, 8'h29, 8'h29, 8'h29, 8'h26, 8'h00};
            7'd51:  g = {8'h12, 8'h21, 8'h25, 8'h25, 8'h1A, 8'h00};
            7'd52:  g = {8'h0C, 8'h0A, 8'h09, 8'h3F, 8'h08, 8'h00};
            7'd53:  g = {8'h17, 8'h25, 8'h25, 8'h25, 8'h19, 8'h00};
            7'd54:  g = {8'h1E, 8'h25, 8'h25, 8'h25, 8'h18, 8'h00};
            7'd55:  g = {8'h01, 8'h01, 8'h39, 8'h05, 8'h03, 8'h00};
            7'd56:  g = {8'h1A, 8'h25, 8'h25, 8'h25, 8'h1A, 8'h00};
            7'd57:  g = {8'h06, 8'h29, 8'h29, 8'h29, 8'h1E, 8'h00};
            7'd58:  g = {8'h00, 8'h14, 8'h14, 8'h00, 8'h00, 8'h00};
            7'd59:  g = {8'h00, 8'h20, 8'h14, 8'h00, 8'h00, 8'h00};
            7'd60:  g = {8'h08, 8'h14, 8'h22, 8'h00, 8'h00, 8'h00};
            7'd61:  g = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h00};
            7'd62:  g = {8'h22, 8'h14, 8'h08, 8'h00, 8'h00, 8'h00};
            7'd63:  g = {8'h02, 8'h01, 8'h29, 8'h09, 8'h06, 8'h00};
            7'd64:  g = {8'h1C, 8'h22, 8'h2D, 8'h2D, 8'h0E, 8'h00};
            7'd65:  g = {8'h3E, 8'h09, 8'h09, 8'h09, 8'h3E, 8'h00};
            7'd66:  g = {8'h3F, 8'h25, 8'h25, 8'h25, 8'h1A, 8'h00};
            7'd67:  g = {8'h1E, 8'h21, 8'h21, 8'h21, 8'h12, 8'h00};
            7'd68:  g = {8'h3F, 8'h21, 8'h21, 8'h21, 8'h1E, 8'h00};
            7'd69:  g = {8'h3F, 8'h25, 8'h25, 8'h25, 8'h21, 8'h00};
            7'd70:  g = {8'h3F, 8'h05, 8'h05, 8'h05, 8'h01, 8'h00};
            7'd71:  g = {8'h1E, 8'h21, 8'h29, 8'h29, 8'h3A, 8'h00};
            7'd72:  g = {8'h3F, 8'h04, 8'h04, 8'h04, 8'h3F, 8'h00};
            7'd73:  g = {8'h00, 8'h21, 8'h3F, 8'h21, 8'h00, 8'h00};
            7'd74:  g = {8'h10, 8'h20, 8'h21, 8'h1F, 8'h01, 8'h00};
            7'd75:  g = {8'h3F, 8'h04, 8'h0A, 8'h11, 8'h20, 8'h00};
            7'd76:  g = {8'h3F, 8'h20, 8'h20, 8'h20, 8'h20, 8'h00};
            7'd77:  g = {8'h3F, 8'h02, 8'h04, 8'h02, 8'h3F, 8'h00};
            7'd78:  g = {8'h3F, 8'h02, 8'h04, 8'h08, 8'h3F, 8'h00};
            7'd79:  g = {8'h1E, 8'h21, 8'h21, 8'h21, 8'h1E, 8'h00};
            7'd80:  g = {8'h3F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00};
            7'd81:  g = {8'h1E, 8'h21, 8'h29, 8'h11, 8'h2E, 8'h00};
            7'd82:  g = {8'h3F, 8'h09, 8'h09, 8'h19, 8'h26, 8'h00};
            7'd83:  g = {8'h26, 8'h25, 8'h25, 8'h25, 8'h19, 8'h00};
            7'd84:  g = {8'h01, 8'h01, 8'h3F, 8'h01, 8'h01, 8'h00};
            7'd85:  g = {8'h1F, 8'h20, 8'h20, 8'h20, 8'h1F, 8'h00};
            7'd86:  g = {8'h0F, 8'h10, 8'h20, 8'h10, 8'h0F, 8'h00};
            7'd87:  g = {8'h1F, 8'h20, 8'h18, 8'h20, 8'h1F, 8'h00};
            7'd88:  g = {8'h3B, 8'h04, 8'h04, 8'h04, 8'h3B, 8'h00};
            7'd89:  g = {8'h03, 8'h04, 8'h3C, 8'h04, 8'h03, 8'h00};
            7'd90:  g = {8'h31, 8'h29, 8'h25, 8'h23, 8'h21, 8'h00};
            7'd91:  g = {8'h00, 8'h3E, 8'h22, 8'h00, 8'h00, 8'h00};
            7'd92:  g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h00};
            7'd93:  g = {8'h00, 8'h22, 8'h3E, 8'h00, 8'h00, 8'h00};
            7'd94:  g = {8'h04, 8'h02, 8'h01, 8'h02, 8'h04, 8'h00};
            7'd95:  g = {8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h00};
            7'd96:  g = {8'h00, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00};
            7'd97:  g = {8'h10, 8'h2A, 8'h2A, 8'h2A, 8'h3C, 8'h00};
            7'd98:  g = {8'h3F, 8'h24, 8'h24, 8'h24, 8'h18, 8'h00};
            7'd99:  g = {8'h1C, 8'h22, 8'h22, 8'h22, 8'h14, 8'h00};
            7'd100: g = {8'h18, 8'h24, 8'h24, 8'h24, 8'h3F, 8'h00};
            7'd101: g = {8'h1C, 8'h2A, 8'h2A, 8'h2A, 8'h04, 8'h00};
            7'd102: g = {8'h04, 8'h3E, 8'h05, 8'h01, 8'h00, 8'h00};
            7'd103: g = {8'h18, 8'h25, 8'h25, 8'h25, 8'h3E, 8'h00};
            7'd104: g = {8'h3F, 8'h04, 8'h04, 8'h04, 8'h38, 8'h00};
            7'd105: g = {8'h00, 8'h24, 8'h3D, 8'h20, 8'h00, 8'h00};
            7'd106: g = {8'h10, 8'h20, 8'h20, 8'h1D, 8'h00, 8'h00};
            7'd107: g = {8'h3F, 8'h08, 8'h14, 8'h22, 8'h00, 8'h00};
            7'd108: g = {8'h00, 8'h21, 8'h3F, 8'h20, 8'h00, 8'h00};
            7'd109: g = {8'h3E, 8'h02, 8'h3E, 8'h02, 8'h3C, 8'h00};
            7'd110: g = {8'h3E, 8'h04, 8'h02, 8'h02, 8'h3C, 8'h00};
            7'd111: g = {8'h1C, 8'h22, 8'h22, 8'h22, 8'h1C, 8'h00};
            7'd112: g = {8'h3E, 8'h0A, 8'h0A, 8'h0A, 8'h04, 8'h00};
            7'd113: g = {8'h04, 8'h0A, 8'h0A, 8'h0A, 8'h3E, 8'h00};
            7'd114: g = {8'h3E, 8'h04, 8'h02, 8'h02, 8'h04, 8'h00};
            7'd115: g = {8'h24, 8'h2A, 8'h2A, 8'h2A, 8'h12, 8'h00};
            7'd116: g = {8'h02, 8'h1F, 8'h22, 8'h20, 8'h00, 8'h00};
            7'd117: g = {8'h1E, 8'h20, 8'h20, 8'h20, 8'h3E, 8'h00};
            7'd118: g = {8'h0E, 8'h10, 8'h20, 8'h10, 8'h0E, 8'h00};
            7'd119: g = {8'h1E, 8'h20, 8'h18, 8'h20, 8'h1E, 8'h00};
            7'd120: g = {8'h22, 8'h14, 8'h08, 8'h14, 8'h22, 8'h00};
            7'd121: g = {8'h03, 8'h24, 8'h24, 8'h24, 8'h1F, 8'h00};
            7'd122: g = {8'h22, 8'h32, 8'h2A, 8'h26, 8'h22, 8'h00};
            7'd123: g = {8'h00, 8'h08, 8'h36, 8'h22, 8'h00, 8'h00};
            7'd124: g = {8'h00, 8'h00, 8'h3E, 8'h00, 8'h00, 8'h00};
            7'd125: g = {8'h00, 8'h22, 8'h36, 8'h08, 8'h00, 8'h00};
            7'd126: g = {8'h04, 8'h02, 8'h04, 8'h08, 8'h04, 8'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

    // glyph bits of a character code in scan order (rows, then columns)
    function automatic t_scan glyph_scan(input logic [CODE_W-1:0] code);
        t_glyph g;
        t_scan  m;
        g = code[CODE_W-1] ? '0 : glyph_lookup(code[CODE_W-2:0]);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            for (int c = 0; c < GLYPH_COLUMNS; c++) begin
                m[r*GLYPH_COLUMNS + c] = g[c][r];
            end
        end
        return m;
    endfunction

endpackage

// File: sv/gtpw_channels.sv
// ----------------------------------------------------------------------------
// gtpw channels: valid/ready interfaces of the text pixel writer
// Character input, pixel write output and configuration write channel.
// ----------------------------------------------------------------------------
interface gtpw_in_if;
    logic                         valid;
    logic                         ready;
    logic [gtpw_pkg::CODE_W-1:0]  char_code;
    logic [gtpw_pkg::COORD_W-1:0] start_x;
    logic [gtpw_pkg::COORD_W-1:0] start_y;
    logic                         first_of_text;

    modport source (output valid, char_code, start_x, start_y, first_of_text,
                    input ready);
    modport sink   (input valid, char_code, start_x, start_y, first_of_text,
                    output ready);
endinterface

interface gtpw_out_if #(
    parameter int ADDRESS_BITS = 20
);
    logic                    valid;
    logic                    ready;
    logic [ADDRESS_BITS-1:0] pixel_address;
    logic                    address_overflow;
    logic                    last_of_char;

    modport source (output valid, pixel_address, address_overflow, last_of_char,
                    input ready);
    modport sink   (input valid, pixel_address, address_overflow, last_of_char,
                    output ready);
endinterface

interface gtpw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gtpw_pkg::CFG_IDX_W-1:0]  index;
    logic [gtpw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/glyph_text_pixel_writer_unit.sv
// ----------------------------------------------------------------------------
// glyph_text_pixel_writer_unit: 6x8 font text renderer to pixel indexes
// Draws one character per item and emits one framebuffer pixel index for
// every set glyph bit, scanning rows then columns.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  i_item    in         char_code, start_x, start_y, first_of_text
//  o_pixel   out        pixel_address, address_overflow, last_of_char
//  i_cfg     in         index, data (0 x_offset, 1 y_offset, 2 line_width)
//
// An item is taken, the row base multiply follows, then the scan walks one
// glyph cell per cycle up to the last set bit while the output register can
// take a pixel. A blank character skips the scan.
// The scan pauses while a pixel waits in the output register; the next item
// is taken while the last pixel still waits. Reset is synchronous and sets
// the registers to their defaults and the character position to zero.
// ----------------------------------------------------------------------------
module glyph_text_pixel_writer_unit #(
    parameter int ADDRESS_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gtpw_in_if.sink    i_item,
    gtpw_out_if.source o_pixel,
    gtpw_cfg_if.sink   i_cfg
);
    import gtpw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration is always taken
    assign i_cfg.ready = 1'b1;

    gtpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_pixel.ready),
        .o_out_valid (o_pixel.valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    gtpw_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_char_code        (i_item.char_code),
        .i_start_x          (i_item.start_x),
        .i_start_y          (i_item.start_y),
        .i_first_of_text    (i_item.first_of_text),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_pixel_address    (o_pixel.pixel_address),
        .o_address_overflow (o_pixel.address_overflow),
        .o_last_of_char     (o_pixel.last_of_char)
    );

endmodule

// File: sv/gtpw_ctrl.sv
// ----------------------------------------------------------------------------
// gtpw_ctrl: sequencer of the text pixel writer
// Accepts a character, runs the row base multiply, then steps the glyph scan
// one cell per cycle while the output register can take a pixel.
// ----------------------------------------------------------------------------
module gtpw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output gtpw_pkg::t_dp_cmd    o_cmd,
    input  gtpw_pkg::t_dp_status i_status
);
    import gtpw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       can_adv;

    assign can_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.load_row_base = 1'b1;
                n_state = i_status.mask_empty ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (can_adv) begin
                    o_cmd.step = 1'b1;
                    o_cmd.emit = i_status.cur_set;
                    if (i_status.rest_empty) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // hold a pixel until taken
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: sv/gtpw_datapath.sv
// ----------------------------------------------------------------------------
// gtpw_datapath: address arithmetic of the text pixel writer
// Holds configuration, the character position, the scan mask and counters,
// and the output payload register.
// ----------------------------------------------------------------------------
module gtpw_datapath #(
    parameter int ADDRESS_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gtpw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gtpw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [gtpw_pkg::CODE_W-1:0]     i_char_code,
    input  logic [gtpw_pkg::COORD_W-1:0]    i_start_x,
    input  logic [gtpw_pkg::COORD_W-1:0]    i_start_y,
    input  logic                            i_first_of_text,
    input  gtpw_pkg::t_dp_cmd               i_cmd,
    output gtpw_pkg::t_dp_status            o_status,
    output logic [ADDRESS_BITS-1:0]         o_pixel_address,
    output logic                            o_address_overflow,
    output logic                            o_last_of_char
);
    import gtpw_pkg::*;

    localparam logic [SUM_W-1:0] ADDR_MAX =
        (SUM_W'(1) << ADDRESS_BITS) - SUM_W'(1);

    logic [OFFS_W-1:0]   r_x_offset;
    logic [OFFS_W-1:0]   r_y_offset;
    logic [LWID_W-1:0]   r_line_width;
    logic [POS_W-1:0]    r_char_pos;
    t_scan               r_mask;
    logic [XBASE_W-1:0]  r_x_base;
    logic [YSUM_W-1:0]   r_y_sum;
    logic [ROWB_W-1:0]   r_row_base;
    logic [COL_W-1:0]    r_col;
    logic [ADDRESS_BITS-1:0] r_pixel_address;
    logic                r_overflow;
    logic                r_last;

    logic [POS_W-1:0]    pos_eff;
    logic [XBASE_W-1:0]  six_pos;
    logic [SUM_W-1:0]    addr_sum;
    logic                addr_ovf;
    logic                rest_empty;

    assign pos_eff  = i_first_of_text ? '0 : r_char_pos;
    assign six_pos  = XBASE_W'({pos_eff, 2'b00}) + XBASE_W'({pos_eff, 1'b0});
    assign addr_sum = SUM_W'(r_row_base) + SUM_W'(r_x_base) + SUM_W'(r_col);
    assign addr_ovf = (addr_sum > ADDR_MAX);

    assign rest_empty          = (r_mask[GLYPH_CELLS-1:1] == '0);
    assign o_status.mask_empty = (r_mask == '0);
    assign o_status.cur_set    = r_mask[0];
    assign o_status.rest_empty = rest_empty;

    assign o_pixel_address    = r_pixel_address;
    assign o_address_overflow = r_overflow;
    assign o_last_of_char     = r_last;

    // configuration registers and character position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset   <= '0;
            r_y_offset   <= '0;
            r_line_width <= LINE_WIDTH_RESET;
            r_char_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_X_OFFSET:   r_x_offset   <= i_cfg_data[OFFS_W-1:0];
                    CFG_Y_OFFSET:   r_y_offset   <= i_cfg_data[OFFS_W-1:0];
                    CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                    default: ;
                endcase
            end
            // advance the position, saturating
            if (i_cmd.load_item) begin
                r_char_pos <= (pos_eff == POS_MAX) ? POS_MAX : pos_eff + POS_W'(1);
            end
        end
    end

    // scan state: latch the item, form the row base, walk the cells
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mask   <= glyph_scan(i_char_code);
            r_x_base <= XBASE_W'(i_start_x) + XBASE_W'(r_x_offset) + six_pos;
            r_y_sum  <= YSUM_W'(i_start_y) + YSUM_W'(r_y_offset);
            r_col    <= '0;
        end
        if (i_cmd.load_row_base) begin
            r_row_base <= ROWB_W'(r_y_sum) * ROWB_W'(r_line_width);
        end
        if (i_cmd.step) begin
            r_mask <= r_mask >> 1;
            if (r_col == COL_LAST) begin
                r_col      <= '0;
                r_row_base <= r_row_base + ROWB_W'(r_line_width);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // output payload, saturated on overflow
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pixel_address <= addr_ovf ? ADDR_MAX[ADDRESS_BITS-1:0]
                                        : addr_sum[ADDRESS_BITS-1:0];
            r_overflow      <= addr_ovf;
            r_last          <= rest_empty;
        end
    end

endmodule
